// File: src/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared types, codes and reset values of the charge port session controller.
// ----------------------------------------------------------------------------
package cpsc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 26;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OVERLOAD_GAP   = 3'd0,
        REG_FULL_GAP       = 3'd1,
        REG_OVERLOAD_RUNS  = 3'd2,
        REG_FULL_RUNS      = 3'd3,
        REG_PULSES_PER_COIN = 3'd4,
        REG_MS_PER_COIN    = 3'd5,
        REG_REPORT_EVERY   = 3'd6
    } reg_index_t;

    localparam logic [15:0] RST_OVERLOAD_GAP    = 16'd100;
    localparam logic [23:0] RST_FULL_GAP        = 24'd60000;
    localparam logic [7:0]  RST_OVERLOAD_RUNS   = 8'd5;
    localparam logic [7:0]  RST_FULL_RUNS       = 8'd5;
    localparam logic [15:0] RST_PULSES_PER_COIN = 16'd1000;
    localparam logic [25:0] RST_MS_PER_COIN     = 26'd3600000;
    localparam logic [7:0]  RST_REPORT_EVERY    = 8'd10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PULSE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STARTED = 3'd1,
        EV_ENERGY  = 3'd2,
        EV_TIME_UP = 3'd3,
        EV_STOPPED = 3'd4,
        EV_REPORT  = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        CLS_NORMAL   = 2'd0,
        CLS_OVERLOAD = 2'd1,
        CLS_FULL     = 2'd2
    } pulse_class_t;

    typedef struct packed {
        logic [15:0] overload_gap_ms;
        logic [23:0] full_gap_ms;
        logic [7:0]  overload_runs;
        logic [7:0]  full_runs;
        logic [15:0] pulses_per_coin;
        logic [25:0] ms_per_coin;
        logic [7:0]  report_every;
    } cfg_t;

    // One accepted item as seen by the processing logic.
    typedef struct packed {
        logic        fire;
        op_t         op;
        logic [7:0]  coins;
        logic        card_session;
    } item_t;

endpackage

// File: src/cpsc_cfg.sv
// ----------------------------------------------------------------------------
// cpsc_cfg
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module cpsc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [cpsc_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0]     wr_data,
    output cpsc_pkg::cfg_t                      cfg
);

    cpsc_pkg::cfg_t cfg_reg;
    cpsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                cpsc_pkg::REG_OVERLOAD_GAP:    cfg_next.overload_gap_ms = wr_data[15:0];
                cpsc_pkg::REG_FULL_GAP:        cfg_next.full_gap_ms     = wr_data[23:0];
                cpsc_pkg::REG_OVERLOAD_RUNS:   cfg_next.overload_runs   = wr_data[7:0];
                cpsc_pkg::REG_FULL_RUNS:       cfg_next.full_runs       = wr_data[7:0];
                cpsc_pkg::REG_PULSES_PER_COIN: cfg_next.pulses_per_coin = wr_data[15:0];
                cpsc_pkg::REG_MS_PER_COIN:     cfg_next.ms_per_coin     = wr_data[25:0];
                cpsc_pkg::REG_REPORT_EVERY:    cfg_next.report_every    = wr_data[7:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overload_gap_ms <= cpsc_pkg::RST_OVERLOAD_GAP;
            cfg_reg.full_gap_ms     <= cpsc_pkg::RST_FULL_GAP;
            cfg_reg.overload_runs   <= cpsc_pkg::RST_OVERLOAD_RUNS;
            cfg_reg.full_runs       <= cpsc_pkg::RST_FULL_RUNS;
            cfg_reg.pulses_per_coin <= cpsc_pkg::RST_PULSES_PER_COIN;
            cfg_reg.ms_per_coin     <= cpsc_pkg::RST_MS_PER_COIN;
            cfg_reg.report_every    <= cpsc_pkg::RST_REPORT_EVERY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/cpsc_classify.sv
// ----------------------------------------------------------------------------
// cpsc_classify
// Millisecond clock and meter pulse gap classifier with run counters.
// ----------------------------------------------------------------------------
module cpsc_classify (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cpsc_pkg::item_t             item,
    input  cpsc_pkg::cfg_t              cfg,
    output cpsc_pkg::pulse_class_t      cls_next
);

    logic [31:0] now_ms_reg, now_ms_next;
    logic [31:0] last_pulse_ms_reg, last_pulse_ms_next;
    logic [7:0]  short_run_reg, short_run_next;
    logic [7:0]  long_run_reg, long_run_next;

    logic [31:0] gap;
    logic [7:0]  short_inc;
    logic [7:0]  long_inc;

    assign gap       = now_ms_reg - last_pulse_ms_reg;
    assign short_inc = short_run_reg + 8'd1;
    assign long_inc  = long_run_reg + 8'd1;

    always_comb begin
        now_ms_next        = now_ms_reg;
        last_pulse_ms_next = last_pulse_ms_reg;
        short_run_next     = short_run_reg;
        long_run_next      = long_run_reg;
        cls_next           = cpsc_pkg::CLS_NORMAL;
        if (item.fire) begin
            case (item.op)
                cpsc_pkg::OP_TICK: begin
                    now_ms_next = now_ms_reg + 32'd1;
                end
                cpsc_pkg::OP_PULSE: begin
                    last_pulse_ms_next = now_ms_reg;
                    if (gap < {16'd0, cfg.overload_gap_ms}) begin
                        short_run_next = short_inc;
                        if (short_inc > cfg.overload_runs) begin
                            cls_next       = cpsc_pkg::CLS_OVERLOAD;
                            short_run_next = 8'd0;
                        end
                    end else if (gap > {8'd0, cfg.full_gap_ms}) begin
                        long_run_next = long_inc;
                        if (long_inc > cfg.full_runs) begin
                            cls_next      = cpsc_pkg::CLS_FULL;
                            long_run_next = 8'd0;
                        end
                    end else begin
                        short_run_next = 8'd0;
                        long_run_next  = 8'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_ms_reg        <= 32'd0;
            last_pulse_ms_reg <= 32'd0;
            short_run_reg     <= 8'd0;
            long_run_reg      <= 8'd0;
        end else begin
            now_ms_reg        <= now_ms_next;
            last_pulse_ms_reg <= last_pulse_ms_next;
            short_run_reg     <= short_run_next;
            long_run_reg      <= long_run_next;
        end
    end

endmodule

// File: src/cpsc_session.sv
// ----------------------------------------------------------------------------
// cpsc_session
// Session state, coin budgets, card reports and the result register.
// ----------------------------------------------------------------------------
module cpsc_session (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cpsc_pkg::item_t             item,
    input  cpsc_pkg::cfg_t              cfg,
    input  cpsc_pkg::pulse_class_t      cls_next,
    output logic                        relay_on,
    output logic                        busy_res,
    output logic [2:0]                  event_res,
    output logic [1:0]                  pulse_class,
    output logic [31:0]                 pulse_count,
    output logic                        was_card
);

    logic        active_reg, active_next;
    logic        card_reg, card_next;
    logic [23:0] budget_reg, budget_next;
    logic [33:0] time_left_reg, time_left_next;
    logic [31:0] pulses_reg, pulses_next;
    logic [7:0]  report_run_reg, report_run_next;

    // Result register; it loads only when an item is accepted.
    cpsc_pkg::event_t       event_reg, event_next;
    cpsc_pkg::pulse_class_t cls_reg;

    logic [31:0] pulses_inc;
    logic [7:0]  report_inc;
    logic [33:0] time_dec;
    logic [23:0] coin_budget;
    logic [33:0] coin_time;

    assign pulses_inc  = pulses_reg + 32'd1;
    assign report_inc  = report_run_reg + 8'd1;
    assign time_dec    = (time_left_reg == 34'd0) ? 34'd0 : time_left_reg - 34'd1;
    assign coin_budget = {16'd0, item.coins} * {8'd0, cfg.pulses_per_coin};
    assign coin_time   = {26'd0, item.coins} * {8'd0, cfg.ms_per_coin};

    always_comb begin
        active_next     = active_reg;
        card_next       = card_reg;
        budget_next     = budget_reg;
        time_left_next  = time_left_reg;
        pulses_next     = pulses_reg;
        report_run_next = report_run_reg;
        event_next      = cpsc_pkg::EV_NONE;
        case (item.op)
            cpsc_pkg::OP_TICK: begin
                if (active_reg && !card_reg) begin
                    time_left_next = time_dec;
                    if (time_dec == 34'd0) begin
                        active_next = 1'b0;
                        event_next  = cpsc_pkg::EV_TIME_UP;
                    end
                end
            end
            cpsc_pkg::OP_PULSE: begin
                if (active_reg) begin
                    pulses_next = pulses_inc;
                    if (!card_reg) begin
                        if (pulses_inc >= {8'd0, budget_reg}) begin
                            active_next = 1'b0;
                            event_next  = cpsc_pkg::EV_ENERGY;
                        end
                    end else begin
                        report_run_next = report_inc;
                        if (report_inc >= cfg.report_every) begin
                            report_run_next = 8'd0;
                            event_next      = cpsc_pkg::EV_REPORT;
                        end
                    end
                end
            end
            cpsc_pkg::OP_START: begin
                // A start replaces any running session.
                active_next = 1'b1;
                card_next   = item.card_session;
                pulses_next = 32'd0;
                event_next  = cpsc_pkg::EV_STARTED;
                if (item.card_session) begin
                    budget_next    = 24'd0;
                    time_left_next = 34'd0;
                end else begin
                    budget_next    = coin_budget;
                    time_left_next = coin_time;
                end
            end
            cpsc_pkg::OP_STOP: begin
                if (active_reg) begin
                    active_next = 1'b0;
                    event_next  = cpsc_pkg::EV_STOPPED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            card_reg       <= 1'b0;
            budget_reg     <= 24'd0;
            time_left_reg  <= 34'd0;
            pulses_reg     <= 32'd0;
            report_run_reg <= 8'd0;
        end else if (item.fire) begin
            active_reg     <= active_next;
            card_reg       <= card_next;
            budget_reg     <= budget_next;
            time_left_reg  <= time_left_next;
            pulses_reg     <= pulses_next;
            report_run_reg <= report_run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item.fire) begin
            event_reg <= event_next;
            cls_reg   <= cls_next;
        end
    end

    // Session fields of the result mirror the session registers after the item.
    assign relay_on    = active_reg;
    assign busy_res    = active_reg;
    assign event_res   = event_reg;
    assign pulse_class = cls_reg;
    assign pulse_count = pulses_reg;
    assign was_card    = card_reg;

endmodule

// File: src/charge_port_session_controller_core.sv
// ----------------------------------------------------------------------------
// charge_port_session_controller_core
// Session controller for one charging outlet: relay, coin budgets, card
// reports and meter pulse gap alarms.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one item per handshake: a millisecond tick, a
//   meter pulse, a session start (coin count and card flag) or a stop.
//   Every accepted item yields exactly one result item on the m_ channel
//   with the relay drive, busy flag, event code, pulse class, pulse count
//   and session kind after that item.
//   The cfg_ channel writes the seven threshold and budget registers by
//   index; it is always ready and should only be used while no item is
//   in flight. Indexes beyond the list are ignored.
//   The result is valid in the cycle after the input handshake. One item is
//   accepted every cycle; the single result register sets that figure, and
//   it is refilled in the same cycle that the receiver takes the old result.
//   When the receiver stalls, the result holds and s_ready stays low.
//   Reset (aresetn low, synchronous) clears the session, the millisecond
//   clock and the run counters, and loads the register defaults.
// ----------------------------------------------------------------------------
module charge_port_session_controller_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [7:0]                          s_coins,
    input  logic                                s_card_session,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_relay_on,
    output logic                                m_busy_res,
    output logic [2:0]                          m_event_res,
    output logic [1:0]                          m_pulse_class,
    output logic [31:0]                         m_pulse_count,
    output logic                                m_was_card,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cpsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cpsc_pkg::cfg_t         cfg;
    cpsc_pkg::item_t        item;
    cpsc_pkg::pulse_class_t cls_next;

    logic m_valid_reg, m_valid_next;
    logic s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    assign item.fire         = s_fire;
    assign item.op           = cpsc_pkg::op_t'(s_operation);
    assign item.coins        = s_coins;
    assign item.card_session = s_card_session;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    cpsc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cpsc_classify u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .cfg      (cfg),
        .cls_next (cls_next)
    );

    cpsc_session u_session (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (item),
        .cfg         (cfg),
        .cls_next    (cls_next),
        .relay_on    (m_relay_on),
        .busy_res    (m_busy_res),
        .event_res   (m_event_res),
        .pulse_class (m_pulse_class),
        .pulse_count (m_pulse_count),
        .was_card    (m_was_card)
    );

    // A stalled result must block new items so that it is never overwritten.
    a_stall_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready
    ) else $error("input accepted while result stalled");

    // A start always opens a session and reports it in the next result.
    a_start_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == cpsc_pkg::OP_START) |=>
            (m_valid && m_busy_res && m_event_res == cpsc_pkg::EV_STARTED)
    ) else $error("start did not produce a started result");

    // Session-ending events leave the port idle with the relay off.
    a_end_is_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == cpsc_pkg::EV_ENERGY ||
                     m_event_res == cpsc_pkg::EV_TIME_UP ||
                     m_event_res == cpsc_pkg::EV_STOPPED)) |-> (!m_busy_res && !m_relay_on)
    ) else $error("session end event with port still busy");

    // Reports come only from card sessions.
    a_report_card: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == cpsc_pkg::EV_REPORT) |-> (m_was_card && m_busy_res)
    ) else $error("report outside a card session");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the charge port session controller. A clocked
// driver sends ticks, meter pulses, starts and stops from a queue. A clocked
// monitor compares every result field by field against an in-bench model of
// the outlet. Register settings change between phases while the block is
// idle. Directed corner cases are followed by random charging sessions.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_PAUSE    = 16;

    // Index 7 is outside the register map; writes to it must change nothing.
    localparam logic [cpsc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        cpsc_pkg::op_t op;
        logic [7:0]    coins;
        logic          card;
    } outlet_item_t;

    typedef struct packed {
        logic                   relay_on;
        logic                   busy;
        cpsc_pkg::event_t       ev;
        cpsc_pkg::pulse_class_t cls;
        logic [31:0]            count;
        logic                   was_card;
    } outlet_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [7:0]  s_coins = '0;
    logic        s_card_session = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_relay_on;
    logic        m_busy_res;
    logic [2:0]  m_event_res;
    logic [1:0]  m_pulse_class;
    logic [31:0] m_pulse_count;
    logic        m_was_card;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [cpsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cpsc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Outlet model state.
    cpsc_pkg::cfg_t outlet_cfg;
    logic [31:0] now_ms = '0;
    logic [31:0] last_pulse_ms = '0;
    logic [7:0]  short_run = '0;
    logic [7:0]  long_run = '0;
    logic        session_on = 1'b0;
    logic        session_card = 1'b0;
    logic [31:0] energy_budget = '0;
    logic [33:0] time_left = '0;
    logic [31:0] session_pulses = '0;
    logic [7:0]  report_run = '0;

    outlet_item_t   outlet_traffic[$];
    outlet_result_t results_due[$];

    logic        sending = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    charge_port_session_controller_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_coins        (s_coins),
        .s_card_session (s_card_session),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_relay_on     (m_relay_on),
        .m_busy_res     (m_busy_res),
        .m_event_res    (m_event_res),
        .m_pulse_class  (m_pulse_class),
        .m_pulse_count  (m_pulse_count),
        .m_was_card     (m_was_card),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int unsigned draw_pause(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_PAUSE);
    endfunction

    // Applies one accepted item to the outlet model and records its result.
    task automatic advance_outlet(input cpsc_pkg::op_t op, input logic [7:0] coins,
                                  input logic card);
        outlet_result_t r;
        logic [31:0]    gap;
        r.ev  = cpsc_pkg::EV_NONE;
        r.cls = cpsc_pkg::CLS_NORMAL;
        case (op)
            cpsc_pkg::OP_TICK: begin
                now_ms = now_ms + 32'd1;
                if (session_on && !session_card) begin
                    if (time_left != '0) begin
                        time_left = time_left - 34'd1;
                    end
                    if (time_left == '0) begin
                        session_on = 1'b0;
                        r.ev = cpsc_pkg::EV_TIME_UP;
                    end
                end
            end
            cpsc_pkg::OP_PULSE: begin
                gap = now_ms - last_pulse_ms;
                if (gap < 32'(outlet_cfg.overload_gap_ms)) begin
                    short_run = short_run + 8'd1;
                    if (short_run > outlet_cfg.overload_runs) begin
                        r.cls = cpsc_pkg::CLS_OVERLOAD;
                        short_run = '0;
                    end
                end else if (gap > 32'(outlet_cfg.full_gap_ms)) begin
                    long_run = long_run + 8'd1;
                    if (long_run > outlet_cfg.full_runs) begin
                        r.cls = cpsc_pkg::CLS_FULL;
                        long_run = '0;
                    end
                end else begin
                    short_run = '0;
                    long_run = '0;
                end
                last_pulse_ms = now_ms;
                if (session_on) begin
                    session_pulses = session_pulses + 32'd1;
                    if (!session_card) begin
                        if (session_pulses >= energy_budget) begin
                            session_on = 1'b0;
                            r.ev = cpsc_pkg::EV_ENERGY;
                        end
                    end else begin
                        // The report counter carries over from one card session to the next.
                        report_run = report_run + 8'd1;
                        if (report_run >= outlet_cfg.report_every) begin
                            report_run = '0;
                            r.ev = cpsc_pkg::EV_REPORT;
                        end
                    end
                end
            end
            cpsc_pkg::OP_START: begin
                session_on = 1'b1;
                session_card = card;
                session_pulses = '0;
                if (card) begin
                    energy_budget = '0;
                    time_left = '0;
                end else begin
                    energy_budget = 32'(coins) * 32'(outlet_cfg.pulses_per_coin);
                    time_left = 34'(coins) * 34'(outlet_cfg.ms_per_coin);
                end
                r.ev = cpsc_pkg::EV_STARTED;
            end
            default: begin
                if (session_on) begin
                    session_on = 1'b0;
                    r.ev = cpsc_pkg::EV_STOPPED;
                end
            end
        endcase
        r.relay_on = session_on;
        r.busy     = session_on;
        r.count    = session_pulses;
        r.was_card = session_card;
        results_due.push_back(r);
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : send_side
        outlet_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
            sending = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_outlet(cpsc_pkg::op_t'(s_operation), s_coins, s_card_session);
                sending = 1'b0;
            end
            if (s_valid && !s_ready) begin
                // Hold the item until it is taken.
            end else if (send_wait != 0) begin
                send_wait = send_wait - 1;
                s_valid <= 1'b0;
            end else if (outlet_traffic.size() != 0) begin
                nxt = outlet_traffic.pop_front();
                s_operation <= nxt.op;
                s_coins <= nxt.coins;
                s_card_session <= nxt.card;
                s_valid <= 1'b1;
                sending = 1'b1;
                send_wait = draw_pause(send_idle);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_side
        outlet_result_t due;
        int unsigned    next_wait;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            next_wait = (recv_wait != 0) ? recv_wait - 1 : 0;
            if (m_valid && m_ready) begin
                next_wait = draw_pause(recv_idle);
                if (results_due.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    error_count++;
                end else begin
                    due = results_due.pop_front();
                    check_field("relay_on", 32'(due.relay_on), 32'(m_relay_on));
                    check_field("busy_res", 32'(due.busy), 32'(m_busy_res));
                    check_field("event_res", 32'(due.ev), 32'(m_event_res));
                    check_field("pulse_class", 32'(due.cls), 32'(m_pulse_class));
                    check_field("pulse_count", due.count, m_pulse_count);
                    check_field("was_card", 32'(due.was_card), 32'(m_was_card));
                end
            end
            recv_wait <= next_wait;
            m_ready <= (next_wait == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_item(input cpsc_pkg::op_t op, input logic [7:0] coins,
                              input logic card);
        outlet_item_t it;
        it.op = op;
        it.coins = coins;
        it.card = card;
        outlet_traffic.push_back(it);
    endtask

    // Mostly whole sessions: a start, runs of ticks and pulses, sometimes a stop.
    // About one draw in ten queues a single fully random item instead of a session.
    task automatic queue_traffic(input int unsigned count, input int unsigned tick_span);
        int unsigned added;
        int unsigned body;
        int unsigned ticks;
        logic [7:0]  coins;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(cpsc_pkg::op_t'($urandom_range(0, 3)), 8'($urandom),
                           1'($urandom));
                added++;
            end else begin
                coins = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                queue_item(cpsc_pkg::OP_START, coins, 1'($urandom));
                added++;
                body = $urandom_range(2, 24);
                repeat (body) begin
                    ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tick_span)
                                                        : $urandom_range(0, 1);
                    repeat (ticks) begin
                        queue_item(cpsc_pkg::OP_TICK, 8'($urandom), 1'($urandom));
                        added++;
                    end
                    queue_item(cpsc_pkg::OP_PULSE, 8'($urandom), 1'($urandom));
                    added++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    queue_item(cpsc_pkg::OP_STOP, 8'($urandom), 1'($urandom));
                    added++;
                end
            end
        end
    endtask

    // Returns once every queued item has been sent and its result checked.
    task automatic wait_idle();
        while (outlet_traffic.size() != 0 || sending || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    // Called at a clock edge; returns at the edge where the write is taken,
    // with cfg_valid still high.
    task automatic write_reg(input logic [cpsc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cpsc_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            cpsc_pkg::REG_OVERLOAD_GAP:    outlet_cfg.overload_gap_ms = data[15:0];
            cpsc_pkg::REG_FULL_GAP:        outlet_cfg.full_gap_ms = data[23:0];
            cpsc_pkg::REG_OVERLOAD_RUNS:   outlet_cfg.overload_runs = data[7:0];
            cpsc_pkg::REG_FULL_RUNS:       outlet_cfg.full_runs = data[7:0];
            cpsc_pkg::REG_PULSES_PER_COIN: outlet_cfg.pulses_per_coin = data[15:0];
            cpsc_pkg::REG_MS_PER_COIN:     outlet_cfg.ms_per_coin = data[25:0];
            cpsc_pkg::REG_REPORT_EVERY:    outlet_cfg.report_every = data[7:0];
            default: ;
        endcase
    endtask

    task automatic load_registers(input cpsc_pkg::cfg_t c);
        write_reg(cpsc_pkg::REG_OVERLOAD_GAP, cpsc_pkg::CFG_DATA_W'(c.overload_gap_ms));
        write_reg(cpsc_pkg::REG_FULL_GAP, cpsc_pkg::CFG_DATA_W'(c.full_gap_ms));
        write_reg(cpsc_pkg::REG_OVERLOAD_RUNS, cpsc_pkg::CFG_DATA_W'(c.overload_runs));
        write_reg(cpsc_pkg::REG_FULL_RUNS, cpsc_pkg::CFG_DATA_W'(c.full_runs));
        write_reg(cpsc_pkg::REG_PULSES_PER_COIN, cpsc_pkg::CFG_DATA_W'(c.pulses_per_coin));
        write_reg(cpsc_pkg::REG_MS_PER_COIN, c.ms_per_coin);
        write_reg(cpsc_pkg::REG_REPORT_EVERY, cpsc_pkg::CFG_DATA_W'(c.report_every));
        write_reg(REG_UNMAPPED, cpsc_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        cpsc_pkg::cfg_t c;
        outlet_cfg.overload_gap_ms = cpsc_pkg::RST_OVERLOAD_GAP;
        outlet_cfg.full_gap_ms     = cpsc_pkg::RST_FULL_GAP;
        outlet_cfg.overload_runs   = cpsc_pkg::RST_OVERLOAD_RUNS;
        outlet_cfg.full_runs       = cpsc_pkg::RST_FULL_RUNS;
        outlet_cfg.pulses_per_coin = cpsc_pkg::RST_PULSES_PER_COIN;
        outlet_cfg.ms_per_coin     = cpsc_pkg::RST_MS_PER_COIN;
        outlet_cfg.report_every    = cpsc_pkg::RST_REPORT_EVERY;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners on the reset settings, no idling.
        queue_item(cpsc_pkg::OP_STOP, 8'hFF, 1'b1);
        queue_item(cpsc_pkg::OP_PULSE, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_TICK, 8'hFF, 1'b1);
        queue_item(cpsc_pkg::OP_START, 8'd0, 1'b0);
        queue_item(cpsc_pkg::OP_TICK, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_START, 8'd0, 1'b0);
        queue_item(cpsc_pkg::OP_PULSE, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_START, 8'hFF, 1'b1);
        // Back-to-back pulses raise an overload alarm and reach a card report.
        repeat (10) queue_item(cpsc_pkg::OP_PULSE, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_START, 8'hFF, 1'b0);
        queue_item(cpsc_pkg::OP_PULSE, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_STOP, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_STOP, 8'hFF, 1'b1);
        queue_item(cpsc_pkg::OP_START, 8'd1, 1'b0);
        queue_item(cpsc_pkg::OP_TICK, 8'h00, 1'b0);
        queue_item(cpsc_pkg::OP_STOP, 8'h00, 1'b0);
        wait_idle();

        // Small thresholds so that every event and alarm comes up often.
        c.overload_gap_ms = 16'd4;
        c.full_gap_ms     = 24'd6;
        c.overload_runs   = 8'd2;
        c.full_runs       = 8'd1;
        c.pulses_per_coin = 16'd3;
        c.ms_per_coin     = 26'd15;
        c.report_every    = 8'd3;
        load_registers(c);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        queue_traffic(350, 12);
        wait_idle();

        // All registers at zero: zero budgets, a report on every card pulse.
        c = '0;
        load_registers(c);
        send_idle = 1'b1;
        recv_idle = 1'b0;
        queue_traffic(200, 4);
        wait_idle();

        // All registers at their maximum.
        c.overload_gap_ms = '1;
        c.full_gap_ms     = '1;
        c.overload_runs   = '1;
        c.full_runs       = '1;
        c.pulses_per_coin = '1;
        c.ms_per_coin     = '1;
        c.report_every    = '1;
        load_registers(c);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        queue_traffic(200, 8);
        wait_idle();

        repeat (4) begin
            c.overload_gap_ms = 16'($urandom_range(0, 10));
            c.full_gap_ms     = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 20));
            c.overload_runs   = 8'($urandom_range(0, 8));
            c.full_runs       = 8'($urandom_range(0, 8));
            c.pulses_per_coin = 16'($urandom_range(0, 20));
            c.ms_per_coin     = 26'($urandom_range(0, 40));
            c.report_every    = 8'($urandom_range(0, 12));
            load_registers(c);
            send_idle = 1'($urandom);
            recv_idle = 1'($urandom);
            queue_traffic(125, 25);
            wait_idle();
        end

        if (error_count == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
